[src/otpt_pkg.sv]
// Shared types and constants of the one-shot/periodic tick timer.
// Used by every module under src; depends on nothing else.
package otpt_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;
  localparam logic [31:0] MsDivisor   = 32'd1000;
  localparam logic [6:0]  PctFull     = 7'd100;

  localparam logic [31:0] TickRateRst = 32'd1000;
  localparam logic [31:0] TimerValRst = 32'd1000;
  localparam logic        UnitSelRst  = 1'b1;
  localparam logic [1:0]  InitModeRst = 2'd1;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_ONESHOT  = 2'd1,
    MODE_PERIODIC = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_POLL      = 2'd0,
    CMD_CONSTRUCT = 2'd1,
    CMD_RESTART   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_TICK_RATE = 2'd0,
    REG_TIMER_VAL = 2'd1,
    REG_UNIT_SEL  = 2'd2,
    REG_INIT_MODE = 2'd3
  } reg_e;

  typedef struct packed {
    logic [31:0] tick_rate_hz;
    logic [31:0] timer_value;
    logic        unit_select;
    logic [1:0]  initial_mode;
  } cfg_t;

endpackage

[src/otpt_div.sv]
// Restoring serial divider, one quotient bit per cycle, 64 by 32 bits.
// The caller guarantees that the upper half of the dividend is below the divisor.
// Depends on otpt_pkg.
module otpt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import otpt_pkg::*;

  logic [31:0] rem_q, quo_q, dsr_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[63:32];
      quo_q <= dividend_i[31:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("divider done without a run");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held for two cycles");

endmodule

[src/otpt_cfg.sv]
// Configuration register file behind an APB-style port.
// Depends on otpt_pkg for the register map and the reset values.
module otpt_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [otpt_pkg::AddrW-1:0]    paddr,
  input  logic [otpt_pkg::DataW-1:0]    pwdata,
  output logic [otpt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output otpt_pkg::cfg_t                cfg_o
);
  import otpt_pkg::*;

  cfg_t cfg_q;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_rate_hz <= TickRateRst;
      cfg_q.timer_value  <= TimerValRst;
      cfg_q.unit_select  <= UnitSelRst;
      cfg_q.initial_mode <= InitModeRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_TICK_RATE: cfg_q.tick_rate_hz <= pwdata;
        REG_TIMER_VAL: cfg_q.timer_value  <= pwdata;
        REG_UNIT_SEL:  cfg_q.unit_select  <= pwdata[0];
        REG_INIT_MODE: cfg_q.initial_mode <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TICK_RATE: prdata = cfg_q.tick_rate_hz;
      REG_TIMER_VAL: prdata = cfg_q.timer_value;
      REG_UNIT_SEL:  prdata = {31'd0, cfg_q.unit_select};
      REG_INIT_MODE: prdata = {30'd0, cfg_q.initial_mode};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/oneshot_periodic_tick_timer.sv]
// Top level of the one-shot/periodic compare timer against an external tick count.
// A poll, a restart or an unknown command goes straight to the apply step; a construct first
// computes its period, in millisecond units after a saturation check, with a pass of the
// shared divider, which a saturated period skips. Every beat then takes a progress pass of
// the same divider, skipped when its progress is full, and output stalls delay every result.
// Throughput: the next beat is accepted the cycle after a result registers. Reset: timer disabled.
module oneshot_periodic_tick_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [otpt_pkg::AddrW-1:0]    paddr,
  input  logic [otpt_pkg::DataW-1:0]    pwdata,
  output logic [otpt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [31:0]                   current_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          finished_o,
  output logic [6:0]                    progress_percent_o,
  output logic [1:0]                    timer_mode_o
);
  import otpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MSCHK, ST_PDIV, ST_APPLY, ST_SCALE, ST_QDIV, ST_DONE
  } state_e;

  state_e      state_q;
  cfg_t        cfg;
  logic [1:0]  cmd_q;
  logic [31:0] now_q, per_q, period_q, deadline_q;
  logic [63:0] prod_q;
  logic [6:0]  pct_q;
  mode_e       mode_q;
  logic        fin_q;
  logic        out_valid_q, out_fin_q;
  logic [6:0]  out_pct_q;
  logic [1:0]  out_mode_q;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor, div_quot;
  logic        ms_sat;
  logic [31:0] elapsed;
  logic [38:0] elapsed_w;
  logic        accept;
  logic        out_load;

  otpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign ms_sat     = (prod_q[63:32] >= MsDivisor);
  assign elapsed    = now_q - deadline_q + period_q;
  assign elapsed_w  = {7'd0, elapsed};
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_MUL: begin
        if (!cfg.unit_select && cfg.timer_value != 32'd0) begin
          div_start    = 1'b1;
          div_dividend = {32'd0, cfg.tick_rate_hz};
          div_divisor  = cfg.timer_value;
        end
      end
      ST_MSCHK: begin
        if (!ms_sat) begin
          div_start    = 1'b1;
          div_dividend = prod_q;
          div_divisor  = MsDivisor;
        end
      end
      ST_SCALE: begin
        if (period_q != 32'd0 && elapsed < period_q) begin
          div_start    = 1'b1;
          div_dividend = {25'd0, (elapsed_w << 6) + (elapsed_w << 5) + (elapsed_w << 2)};
          div_divisor  = period_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_DISABLED;
      period_q    <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= command_i;
            now_q   <= current_ticks_i;
            fin_q   <= 1'b0;
            state_q <= (cmd_e'(command_i) == CMD_CONSTRUCT) ? ST_MUL : ST_APPLY;
          end
        end
        ST_MUL: begin
          prod_q <= {32'd0, cfg.timer_value} * {32'd0, cfg.tick_rate_hz};
          if (cfg.unit_select) begin
            state_q <= ST_MSCHK;
          end else if (cfg.timer_value == 32'd0) begin
            per_q   <= AllOnes;
            state_q <= ST_APPLY;
          end else begin
            state_q <= ST_PDIV;
          end
        end
        ST_MSCHK: begin
          if (ms_sat) begin
            per_q   <= AllOnes;
            state_q <= ST_APPLY;
          end else begin
            state_q <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (div_done) begin
            per_q   <= div_quot;
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state_q <= ST_SCALE;
          case (cmd_e'(cmd_q))
            CMD_POLL: begin
              if (mode_q != MODE_DISABLED && now_q >= deadline_q) begin
                fin_q <= 1'b1;
                if (mode_q == MODE_PERIODIC) begin
                  deadline_q <= now_q + period_q;
                end else begin
                  mode_q <= MODE_DISABLED;
                end
              end
            end
            CMD_CONSTRUCT: begin
              period_q   <= per_q;
              deadline_q <= now_q + per_q;
              mode_q     <= (cfg.initial_mode <= MODE_PERIODIC) ?
                            mode_e'(cfg.initial_mode) : MODE_DISABLED;
            end
            CMD_RESTART: begin
              deadline_q <= now_q + period_q;
              if (mode_q == MODE_DISABLED) begin
                mode_q <= MODE_ONESHOT;
              end
            end
            default: ;
          endcase
        end
        ST_SCALE: begin
          if (div_start) begin
            state_q <= ST_QDIV;
          end else begin
            pct_q   <= PctFull;
            state_q <= ST_DONE;
          end
        end
        ST_QDIV: begin
          if (div_done) begin
            pct_q   <= div_quot[6:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_fin_q   <= fin_q;
            out_pct_q   <= pct_q;
            out_mode_q  <= mode_q;
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign finished_o         = out_fin_q;
  assign progress_percent_o = out_pct_q;
  assign timer_mode_o       = out_mode_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> progress_percent_o <= PctFull) else $error("progress above full");
  a_expiry_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> timer_mode_o != MODE_ONESHOT)
    else $error("expired one-shot still armed");
  a_div_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PDIV || state_q == ST_QDIV) |-> div_busy || div_done)
    else $error("sequencer waiting on an idle divider");
  a_rearm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCALE && cmd_q == CMD_RESTART && period_q != 32'd0 |-> elapsed == 32'd0)
    else $error("restart did not re-arm from the present tick");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the one-shot/periodic compare timer against a tick count.
// Depends on otpt_pkg and oneshot_periodic_tick_timer; a scoreboard class predicts results.
module tb_top;
  import otpt_pkg::*;

  localparam logic [1:0]  CmdUnknown    = 2'd3;
  localparam logic [1:0]  ModeUnknown   = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 80;
  localparam int unsigned BeatsPerPhase = 100;
  localparam int unsigned RandomPhases  = 8;

  typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;

  typedef struct packed {
    logic       finished;
    logic [6:0] progress;
    logic [1:0] mode;
  } timer_result_t;

  class timer_scoreboard;
    cfg_t            cfg;
    mode_e           run_mode;
    logic [31:0]     period_len;
    logic [31:0]     deadline;
    timer_result_t   pending[$];
    int unsigned     beats_noted;
    int unsigned     results_checked;
    int unsigned     expiries;
    int unsigned     mismatches;

    function new();
      cfg.tick_rate_hz = TickRateRst;
      cfg.timer_value  = TimerValRst;
      cfg.unit_select  = UnitSelRst;
      cfg.initial_mode = InitModeRst;
      run_mode         = MODE_DISABLED;
      period_len       = '0;
      deadline         = '0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] val);
      case (idx)
        REG_TICK_RATE: cfg.tick_rate_hz = val;
        REG_TIMER_VAL: cfg.timer_value = val;
        REG_UNIT_SEL:  cfg.unit_select = val[0];
        REG_INIT_MODE: cfg.initial_mode = val[1:0];
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] cmd, logic [31:0] now);
      logic [63:0]   prod;
      logic [63:0]   share;
      timer_result_t r;
      r.finished = 1'b0;
      case (cmd)
        CMD_POLL: begin
          if (run_mode != MODE_DISABLED && now >= deadline) begin
            r.finished = 1'b1;
            if (run_mode == MODE_PERIODIC) deadline = now + period_len;
            else run_mode = MODE_DISABLED;
          end
        end
        CMD_CONSTRUCT: begin
          if (!cfg.unit_select) begin
            period_len = (cfg.timer_value == '0) ? AllOnes
                                                 : cfg.tick_rate_hz / cfg.timer_value;
          end else begin
            prod = ({32'd0, cfg.timer_value} * {32'd0, cfg.tick_rate_hz}) / {32'd0, MsDivisor};
            period_len = (prod > {32'd0, AllOnes}) ? AllOnes : prod[31:0];
          end
          run_mode = (cfg.initial_mode <= MODE_PERIODIC) ? mode_e'(cfg.initial_mode)
                                                        : MODE_DISABLED;
          deadline = now + period_len;
        end
        CMD_RESTART: begin
          deadline = now + period_len;
          if (run_mode == MODE_DISABLED) run_mode = MODE_ONESHOT;
        end
        default: ;
      endcase
      if (period_len == '0) begin
        r.progress = PctFull;
      end else begin
        share = ({32'd0, now - (deadline - period_len)} * 64'd100) / {32'd0, period_len};
        r.progress = (share > 64'd100) ? PctFull : share[6:0];
      end
      r.mode = run_mode;
      pending.push_back(r);
      beats_noted++;
    endfunction

    function void check_result(logic fin, logic [6:0] pct, logic [1:0] mode);
      timer_result_t r;
      if (pending.size() == 0) begin
        $error("result with no beat outstanding: finished %0d, progress %0d, mode %0d",
               fin, pct, mode);
        mismatches++;
        return;
      end
      r = pending.pop_front();
      results_checked++;
      if (r.finished) expiries++;
      if (fin !== r.finished) begin
        $error("finished: expected %0d, got %0d", r.finished, fin);
        mismatches++;
      end
      if (pct !== r.progress) begin
        $error("progress_percent: expected %0d, got %0d", r.progress, pct);
        mismatches++;
      end
      if (mode !== r.mode) begin
        $error("timer_mode: expected %0d, got %0d", r.mode, mode);
        mismatches++;
      end
    endfunction
  endclass

  timer_scoreboard sb = new();

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [AddrW-1:0]  paddr           = '0;
  logic [DataW-1:0]  pwdata          = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        command_i       = CMD_POLL;
  logic [31:0]       current_ticks_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              finished_o;
  logic [6:0]        progress_percent_o;
  logic [1:0]        timer_mode_o;

  int unsigned       src_idle_pct    = 0;
  int unsigned       snk_stall_pct   = 0;
  int unsigned       stuck_cycles    = 0;
  int unsigned       settings_count  = 0;
  logic [31:0]       tick_now        = '0;

  oneshot_periodic_tick_timer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .current_ticks_i    (current_ticks_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .finished_o         (finished_o),
    .progress_percent_o (progress_percent_o),
    .timer_mode_o       (timer_mode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
  end

  // Beats, results and register writes are all observed here, on the values before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_beat(command_i, current_ticks_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(finished_o, progress_percent_o, timer_mode_o);
      if (psel && penable && pwrite && pready) sb.write_reg(reg_e'(paddr[3:2]), pwdata);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic set_pace(pace_e p);
    case (p)
      PACE_FULL:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      PACE_SRC_IDLE:  begin src_idle_pct = 76; snk_stall_pct = 0;  end
      PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 76; end
      default:        begin src_idle_pct = 24; snk_stall_pct = 24; end
    endcase
  endtask

  task automatic send_beat(logic [1:0] cmd, logic [31:0] ticks);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    current_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The sender holds off until every outstanding beat has produced its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] rate, logic [31:0] value, logic unit,
                           logic [1:0] mode);
    drain();
    apb_write(REG_TICK_RATE, rate);
    apb_write(REG_TIMER_VAL, value);
    apb_write(REG_UNIT_SEL, {31'd0, unit});
    apb_write(REG_INIT_MODE, {30'd0, mode});
    settings_count++;
  endtask

  task automatic random_config();
    logic [31:0] rate;
    logic [31:0] value;
    logic        unit;
    logic [1:0]  mode;
    int unsigned pick;
    rate  = $urandom_range(1, 4000);
    value = $urandom_range(1, 1500);
    unit  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin rate = $urandom; value = $urandom; end
      1: begin unit = 1'b0; value = '0; end
      2: begin unit = 1'b1; rate = AllOnes; value = AllOnes; end
      3: begin unit = 1'b0; rate = 32'd1; value = $urandom_range(2, 100); end
      default: ;
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) mode = MODE_DISABLED;
    else if (pick == 1) mode = ModeUnknown;
    else if (pick < 6) mode = MODE_ONESHOT;
    else mode = MODE_PERIODIC;
    configure(rate, value, unit, mode);
  endtask

  // Mostly polls whose tick count creeps towards the deadline, so that expiries and
  // periodic re-arms come often; the rest are restarts, constructs, unknown commands and odd tick values.
  task automatic random_beats(int unsigned count);
    logic [1:0]  cmd;
    logic [31:0] reach;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 12) cmd = CMD_CONSTRUCT;
      else if (pick < 30) cmd = CMD_RESTART;
      else if (pick < 36) cmd = CmdUnknown;
      else cmd = CMD_POLL;
      reach = (sb.period_len >> 1) + 32'd1;
      pick  = $urandom_range(0, 99);
      if (pick < 70) tick_now = tick_now + $urandom_range(0, reach);
      else if (pick < 85) tick_now = sb.deadline + $urandom_range(0, 2) - 32'd1;
      else if (pick < 95) tick_now = $urandom;
      else tick_now = ($urandom_range(0, 1) != 0) ? AllOnes : 32'd0;
      send_beat(cmd, tick_now);
    end
  endtask

  initial begin
    int unsigned leftover;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_pace(PACE_FULL);

    // Out of reset the timer is disabled with a zero period.
    send_beat(CMD_POLL, 32'd0);
    send_beat(CmdUnknown, AllOnes);
    send_beat(CMD_RESTART, 32'd100);
    send_beat(CMD_POLL, 32'd100);
    send_beat(CMD_CONSTRUCT, 32'd0);
    send_beat(CMD_POLL, 32'd500);
    send_beat(CMD_POLL, 32'd1000);
    send_beat(CMD_POLL, 32'd2000);

    // A zero frequency would divide by zero, so the period saturates instead.
    configure(AllOnes, 32'd0, 1'b0, MODE_PERIODIC);
    send_beat(CMD_CONSTRUCT, 32'd0);
    send_beat(CMD_POLL, 32'hFFFF_FFFE);
    send_beat(CMD_POLL, AllOnes);

    // A deadline that wraps past zero expires at the very next poll.
    configure(32'd1000, 32'd10, 1'b0, MODE_PERIODIC);
    send_beat(CMD_CONSTRUCT, 32'hFFFF_FFF0);
    send_beat(CMD_POLL, 32'hFFFF_FFF8);
    send_beat(CmdUnknown, 32'h20);
    send_beat(CMD_RESTART, 32'h30);

    // The millisecond period overflows, and an unknown mode constructs a disabled timer.
    configure(AllOnes, AllOnes, 1'b1, ModeUnknown);
    send_beat(CMD_CONSTRUCT, 32'd7);
    send_beat(CMD_POLL, 32'd8);
    send_beat(CMD_RESTART, 32'd9);

    configure(32'd1, AllOnes, 1'b0, MODE_ONESHOT);
    send_beat(CMD_CONSTRUCT, 32'd50);
    send_beat(CMD_POLL, 32'd50);

    configure(32'd1, 32'd0, 1'b1, MODE_DISABLED);
    send_beat(CMD_CONSTRUCT, 32'd0);
    send_beat(CMD_RESTART, 32'd3);
    send_beat(CMD_POLL, 32'd2);

    tick_now = $urandom;
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      random_config();
      set_pace(pace_e'(ph / 2));
      random_beats(BeatsPerPhase);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    leftover = sb.pending.size();
    if (leftover != 0) $error("%0d expected results never arrived", leftover);

    $display("summary: %0d beats sent, %0d results checked, %0d expiries seen",
             sb.beats_noted, sb.results_checked, sb.expiries);
    $display("summary: %0d register settings, four pacing schemes", settings_count);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
